/* src/rsq_pkg.sv */
// Shared constants, types and state codes for the R squared accumulator.
// Used by rsq_ctrl, rsq_dp and r_square_accumulator; no dependencies.
`default_nettype none

package rsq_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS   = 65536;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = 24;
  localparam int STATUS_W    = 2;

  localparam int CNT_W    = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int MAG_W    = SUM_W - 1;
  localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 1;
  localparam int ESS_W    = 2 * SAMPLE_BITS + CNT_W + 1;
  localparam int SQ_LO_W  = SQ_W / 2;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int ESS_LO_W = ESS_W / 2;
  localparam int ESS_HI_W = ESS_W - ESS_LO_W;
  localparam int OP_W     = MAG_W;
  localparam int PROD_W   = 2 * OP_W;
  localparam int A_W      = CNT_W + SQ_W;
  localparam int B_W      = 2 * MAG_W;
  localparam int NUM_W    = CNT_W + ESS_W;
  localparam int DEN_W    = A_W;
  localparam int DVD_W    = NUM_W + FRAC_BITS;
  localparam int Q_W      = ((OUT_BITS > FRAC_BITS) ? OUT_BITS : FRAC_BITS) + 1;
  localparam int STEP_W   = $clog2(DVD_W);

  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PAIRS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DVD_W - 1);

  localparam logic [Q_W-1:0]        ONE_Q   = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0]        LIM_Q   = ONE_Q + (Q_W'(1) << (OUT_BITS - 1));
  localparam logic signed [Q_W:0]   RES_MAX = (Q_W + 1)'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [OUT_BITS-1:0]   OUT_MIN = OUT_BITS'(1) << (OUT_BITS - 1);

  typedef enum logic [STATUS_W-1:0] {
    RSQ_OK   = 2'd0,
    RSQ_FLAT = 2'd1,
    RSQ_LONG = 2'd2
  } rsq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } rsq_state_e;

  typedef struct packed {
    logic              acc;
    logic              mul;
    logic              check;
    logic              div;
    logic              load;
    logic [STEP_W-1:0] step;
  } rsq_cmd_t;

  typedef struct packed {
    logic overflow;
    logic var_zero;
    logic out_free;
  } rsq_sts_t;

endpackage

`default_nettype wire

/* src/rsq_ctrl.sv */
// Sequencer for the R squared accumulator: accepts pairs, then steps the
// datapath through the multiply, check and divide phases. Uses rsq_pkg.
`default_nettype none

module rsq_ctrl
  import rsq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  input  wire logic     s_tlast_i,
  input  wire rsq_sts_t sts_i,
  output logic          s_tready_o,
  output rsq_cmd_t      cmd_o
);

  rsq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.acc  = s_tvalid_i;
        if (s_tvalid_i && s_tlast_i) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = step_q + STEP_W'(1);
        if (step_q == MUL_LAST) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        step_d      = '0;
        if (sts_i.overflow || sts_i.var_zero) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        step_d    = step_q + STEP_W'(1);
        if (step_q == DIV_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_ctrl_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result loaded while output register occupied");

  a_ctrl_skip_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && sts_i.overflow) |=> state_q == ST_DONE)
    else $error("division started on an overlong block");

  a_ctrl_mul_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> step_q <= MUL_LAST)
    else $error("multiply step out of range");

  a_ctrl_last_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_tvalid_i && s_tlast_i) |=> state_q == ST_MUL && step_q == '0)
    else $error("block end did not start the multiply phase");

endmodule

`default_nettype wire

/* src/rsq_dp.sv */
// Datapath of the R squared accumulator: running sums, shared multiplier,
// bit-serial divider and output register. Uses rsq_pkg; driven by rsq_ctrl.
`default_nettype none

module rsq_dp
  import rsq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rsq_cmd_t               cmd_i,
  input  wire logic [SAMPLE_BITS-1:0] ref_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] test_sample_i,
  input  wire logic                   m_tready_i,
  output rsq_sts_t                    sts_o,
  output logic                        m_tvalid_o,
  output logic [OUT_BITS-1:0]         r_square_o,
  output logic [STATUS_W-1:0]         status_o
);

  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sq_q;
  logic [ESS_W-1:0]        ess_q;
  logic                    ovf_q;

  logic [MAG_W-1:0]  mag_q;
  logic [PROD_W-1:0] prod_q;
  logic [A_W-1:0]    a_q;
  logic [B_W-1:0]    b_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [Q_W-1:0]    quo_q;
  logic              sat_q;
  logic              var_zero_q;

  logic                      out_valid_q;
  logic [OUT_BITS-1:0]       r_square_q;
  logic [STATUS_W-1:0]       status_q;

  logic signed [SAMPLE_BITS-1:0]   ref_s, test_s;
  logic signed [SAMPLE_BITS:0]     err;
  logic signed [2*SAMPLE_BITS-1:0] ref_sq;
  logic signed [2*SAMPLE_BITS+1:0] err_sq;
  logic [OP_W-1:0]                 op_a, op_b;
  logic                            var_zero;
  logic [DEN_W:0]                  trial;
  logic                            ge;
  logic signed [Q_W:0]             res_w;
  logic [OUT_BITS-1:0]             r_square_d;
  rsq_status_e                     status_d;

  assign ref_s  = $signed(ref_sample_i);
  assign test_s = $signed(test_sample_i);
  assign err    = (SAMPLE_BITS + 1)'(ref_s) - (SAMPLE_BITS + 1)'(test_s);
  assign ref_sq = ref_s * ref_s;
  assign err_sq = err * err;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.step)
      STEP_W'(0): begin
        op_a = OP_W'(cnt_q);
        op_b = OP_W'(sq_q[SQ_LO_W-1:0]);
      end
      STEP_W'(1): begin
        op_a = OP_W'(cnt_q);
        op_b = OP_W'(sq_q[SQ_W-1:SQ_LO_W]);
      end
      STEP_W'(2): begin
        op_a = mag_q;
        op_b = mag_q;
      end
      STEP_W'(3): begin
        op_a = OP_W'(cnt_q);
        op_b = OP_W'(ess_q[ESS_LO_W-1:0]);
      end
      STEP_W'(4): begin
        op_a = OP_W'(cnt_q);
        op_b = OP_W'(ess_q[ESS_W-1:ESS_LO_W]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign var_zero = (A_W'(b_q) >= a_q);
  assign trial    = {rem_q, dvd_q[DVD_W-1]};
  assign ge       = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      ess_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      ess_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (cnt_q == MAX_CNT) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        sum_q <= sum_q + SUM_W'(ref_s);
        sq_q  <= sq_q + SQ_W'($unsigned(ref_sq));
        ess_q <= ess_q + ESS_W'($unsigned(err_sq[2*SAMPLE_BITS-1:0]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= op_a * op_b;
      case (cmd_i.step)
        STEP_W'(0): begin
          mag_q <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
        end
        STEP_W'(1): begin
          a_q <= A_W'(prod_q);
        end
        STEP_W'(2): begin
          a_q <= a_q + (A_W'(prod_q) << SQ_LO_W);
        end
        STEP_W'(3): begin
          b_q <= B_W'(prod_q);
        end
        STEP_W'(4): begin
          num_q <= NUM_W'(prod_q);
        end
        STEP_W'(5): begin
          num_q <= num_q + (NUM_W'(prod_q) << ESS_LO_W);
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.check) begin
      den_q      <= a_q - A_W'(b_q);
      var_zero_q <= var_zero;
      rem_q      <= '0;
      dvd_q      <= {num_q, {FRAC_BITS{1'b0}}};
      quo_q      <= '0;
      sat_q      <= 1'b0;
    end
    if (cmd_i.div) begin
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[Q_W-2:0], ge};
      sat_q <= sat_q | quo_q[Q_W-1];
    end
  end

  always_comb begin
    res_w      = $signed({1'b0, ONE_Q}) - $signed({1'b0, quo_q});
    r_square_d = '0;
    if (ovf_q) begin
      status_d = RSQ_LONG;
    end else if (var_zero_q) begin
      status_d = RSQ_FLAT;
    end else begin
      status_d = RSQ_OK;
      if (sat_q || quo_q >= LIM_Q) begin
        r_square_d = OUT_MIN;
      end else if (res_w > RES_MAX) begin
        r_square_d = RES_MAX[OUT_BITS-1:0];
      end else begin
        r_square_d = res_w[OUT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_square_q <= r_square_d;
      status_q   <= status_d;
    end
  end

  assign sts_o.overflow = ovf_q;
  assign sts_o.var_zero = var_zero;
  assign sts_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o     = out_valid_q;
  assign r_square_o     = r_square_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

/* src/r_square_accumulator.sv */
// Top level of the R squared accumulator: stream ports, controller and
// datapath. Uses rsq_pkg, rsq_ctrl and rsq_dp.
//
// Slave channel: one beat per sample pair; tdata carries the reference and
// test samples (signed Q15), tlast marks the final pair of a block.
// Master channel: one beat per block; tdata carries R squared in signed Q16,
// tuser the status (0 valid, 1 zero reference variance, 2 too many pairs).
// Pairs inside a block are taken at one per cycle. After the tlast beat the
// input stalls while the sums are multiplied out (one shared 32 by 32
// multiplier) and checked, then the quotient is formed by a restoring
// divider at one bit per cycle, which is skipped when the status is non-zero.
// The next block is taken in the cycle after the result is stored.
// A result waiting in the output register does not stop accumulation of the
// next block; only the store of the following result waits for tready.
// Reset clears all sums, the pair count and the output valid flag.
`default_nettype none

module r_square_accumulator
  import rsq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] ref_sample, [31:16] test_sample
  input  wire logic        s_axis_tlast,   // block_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [23:0] r_square
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  rsq_cmd_t cmd;
  rsq_sts_t sts;

  rsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  rsq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .ref_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .test_sample_i (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .m_tready_i    (m_axis_tready),
    .sts_o         (sts),
    .m_tvalid_o    (m_axis_tvalid),
    .r_square_o    (m_axis_tdata),
    .status_o      (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for r_square_accumulator: streams sample pairs, predicts R squared
// and status per block, and checks every result beat field by field.
// Depends on rsq_pkg and the r_square_accumulator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsq_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] ref_s;
    logic signed [SAMPLE_BITS-1:0] test_s;
    logic                          last;
    logic                          drain;
    int                            phase;
  } pair_t;

  typedef struct {
    logic [OUT_BITS-1:0] rsq;
    rsq_status_e         status;
  } rsq_result_t;

  typedef enum {MIX_FULL, MIX_NEAR, MIX_EXACT, MIX_FLAT, MIX_WILD} block_mix_e;

  localparam logic [127:0] Q_ONE = 128'(1) << FRAC_BITS;
  localparam logic [127:0] Q_LIM = Q_ONE + (128'(1) << (OUT_BITS - 1));
  localparam logic [OUT_BITS-1:0] RSQ_FLOOR = {1'b1, {(OUT_BITS - 1){1'b0}}};

  int tx_idle_pct[3] = '{18, 57, 0};
  int rx_idle_pct[3] = '{57, 18, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  pair_t       pair_q[$];
  rsq_result_t rsq_expected[$];

  int     n_pairs;
  longint sum_ref, sum_ref_sq, sum_err_sq;
  bit     too_long;

  int preds_made, results_seen, pairs_sent, errors;
  int n_ok, n_flat, n_long, n_blocks;
  int phase_now;
  int cycles;
  int cycle_limit = 32'h7fffffff;

  r_square_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic fold_pair(input pair_t p);
    longint       r, t, e;
    logic [63:0]  mag;
    logic [127:0] a, b, den, num, quo;
    rsq_result_t  res;
    r = p.ref_s;
    t = p.test_s;
    if (n_pairs >= MAX_PAIRS) begin
      too_long = 1'b1;
    end else begin
      e = r - t;
      n_pairs++;
      sum_ref += r;
      sum_ref_sq += r * r;
      sum_err_sq += e * e;
    end
    if (!p.last) return;
    res.rsq = '0;
    res.status = RSQ_OK;
    if (too_long) begin
      res.status = RSQ_LONG;
      n_long++;
    end else begin
      mag = (sum_ref < 0) ? -sum_ref : sum_ref;
      a = 128'(n_pairs) * 128'(sum_ref_sq);
      b = 128'(mag) * 128'(mag);
      if (b >= a) begin
        res.status = RSQ_FLAT;
        n_flat++;
      end else begin
        den = a - b;
        num = (128'(n_pairs) * 128'(sum_err_sq)) << FRAC_BITS;
        quo = num / den;
        res.rsq = (quo >= Q_LIM) ? RSQ_FLOOR : OUT_BITS'(Q_ONE - quo);
        n_ok++;
      end
    end
    rsq_expected.push_back(res);
    preds_made++;
    n_pairs = 0;
    sum_ref = 0;
    sum_ref_sq = 0;
    sum_err_sq = 0;
    too_long = 1'b0;
  endtask

  task automatic add_pair(input int r, input int t, input bit last, input int phase,
                          input bit drain);
    pair_t p;
    p.ref_s = SAMPLE_BITS'(r);
    p.test_s = SAMPLE_BITS'(t);
    p.last = last;
    p.drain = drain;
    p.phase = phase;
    pair_q.push_back(p);
    if (last) n_blocks++;
  endtask

  task automatic add_block(input int len, input block_mix_e mix, input int phase,
                           input bit drain);
    int r, t, flat_r;
    flat_r = $signed(SAMPLE_BITS'($urandom));
    for (int i = 0; i < len; i++) begin
      r = $signed(SAMPLE_BITS'($urandom));
      t = $signed(SAMPLE_BITS'($urandom));
      case (mix)
        MIX_NEAR: begin
          t = r + $urandom_range(0, 400) - 200;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
        end
        MIX_EXACT: t = r;
        MIX_FLAT:  r = flat_r;
        MIX_WILD:  r = $urandom_range(0, 4) - 2;
        default: ;
      endcase
      add_pair(r, t, i == len - 1, phase, drain && i == 0);
    end
  endtask

  // Present the next pair; hold it until accepted.
  always @(posedge clk_i) begin : drive
    pair_t nxt;
    bit    go;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) begin
        fold_pair(pair_q.pop_front());
        pairs_sent++;
      end
      if (!s_tvalid || s_axis_tready) begin
        go = 1'b0;
        if (pair_q.size() != 0) begin
          nxt = pair_q[0];
          go = !(nxt.drain && results_seen != preds_made) &&
               ($urandom_range(0, 99) >= tx_idle_pct[nxt.phase]);
        end
        s_tvalid <= go;
        if (go) begin
          s_tdata <= {nxt.test_s, nxt.ref_s};
          s_tlast <= nxt.last;
          phase_now <= nxt.phase;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    rsq_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        if (rsq_expected.size() == 0) begin
          $error("unexpected result: r_square %0d, status %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          errors++;
        end else begin
          want = rsq_expected.pop_front();
          if (m_axis_tdata !== want.rsq) begin
            $error("r_square: expected %0d, actual %0d", $signed(want.rsq),
                   $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            errors++;
          end
          results_seen <= results_seen + 1;
        end
      end
      m_tready <= $urandom_range(0, 99) >= rx_idle_pct[phase_now];
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= cycle_limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase, len;
    block_mix_e mix;

    // single pair, flat reference, low saturation, exact fit, extremes, typical
    add_pair(100, 50, 1, 0, 0);
    add_pair(-32768, -32768, 0, 0, 0);
    add_pair(-32768, 32767, 1, 0, 0);
    add_pair(0, 32767, 0, 0, 0);
    add_pair(1, -32768, 1, 0, 0);
    add_pair(1000, 1000, 0, 0, 1);
    add_pair(-2000, -2000, 0, 0, 0);
    add_pair(32767, 32767, 1, 0, 0);
    add_pair(32767, -32768, 0, 0, 0);
    add_pair(-32768, 32767, 0, 0, 0);
    add_pair(0, -1, 1, 0, 0);
    add_pair(5, 3, 0, 0, 0);
    add_pair(-7, -4, 0, 0, 0);
    add_pair(12, 15, 1, 0, 0);

    while (pair_q.size() < 390) begin
      phase = (pair_q.size() < 130) ? 0 : (pair_q.size() < 260) ? 1 : 2;
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mix = MIX_FULL;
        4, 5:       mix = MIX_NEAR;
        6:          mix = MIX_EXACT;
        7:          mix = MIX_FLAT;
        default:    mix = MIX_WILD;
      endcase
      add_block(len, mix, phase, $urandom_range(0, 9) == 0);
    end

    cycle_limit = 10 * pair_q.size() + 1000 * n_blocks + 20000;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() != 0 || results_seen != preds_made) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("Sent %0d sample pairs in %0d blocks under three idle patterns.",
             pairs_sent, n_blocks);
    $display("Checked %0d results: %0d valid, %0d zero variance, %0d over length.",
             preds_made, n_ok, n_flat, n_long);
    if (errors == 0 && rsq_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
src/rsq_pkg.sv
src/rsq_ctrl.sv
src/rsq_dp.sv
src/r_square_accumulator.sv
verif/tb_top.sv
